/* design/first_fit_heap_allocator_core_defines.svh */
// assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("ffha check failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("ffha check failed");

`endif

/* design/ffha_pkg.sv */
package ffha_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 32;
	localparam int AW           = $clog2(HEAP_BYTES);
	localparam int HALF_HEAP    = HEAP_BYTES / 2;
	localparam int BIG_LIMIT    = HEAP_BYTES / 10;
	localparam int MAX_REQ      = HALF_HEAP - HEADER_BYTES;
	localparam int SMALL_MAX    = BIG_LIMIT - HEADER_BYTES;
	localparam bit HAS_BIG      = BIG_LIMIT > HEADER_BYTES;

	typedef logic [AW-1:0] addr_t;

	typedef struct packed {
		addr_t prev;
		addr_t succ;
		addr_t size;
		logic  has_prev;
		logic  has_succ;
		logic  is_free;
		logic  mark;
	} hdr_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE = 3'd1;
	localparam logic [2:0] ST_ZERO      = 3'd2;
	localparam logic [2:0] ST_NO_ROOM   = 3'd3;
	localparam logic [2:0] ST_NULL_FREE = 3'd4;
	localparam logic [2:0] ST_BAD_FREE  = 3'd5;
	localparam logic [2:0] ST_DBL_FREE  = 3'd6;

endpackage

/* design/ffha_hdr_ram.sv */
module ffha_hdr_ram (
	input  logic                clk,
	input  logic                we,
	input  ffha_pkg::addr_t     addr,
	input  ffha_pkg::hdr_t      wdata,
	output ffha_pkg::hdr_t      rdata
);

	ffha_pkg::hdr_t mem [ffha_pkg::HEAP_BYTES];
	ffha_pkg::hdr_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

/* design/first_fit_heap_allocator_core.sv */
// channel  | valid     | stall     | payload
// request  | req_valid | req_stall | opcode, request_size, release_offset
// response | rsp_valid | rsp_stall | status, granted_offset
//
// after reset a clearing pass writes every entry of the header store; req_stall is high
// allocate: a read and a check per header walked, then split and write back
// free: a sequence of single-port header memory reads and writes
// one request at a time; req_stall is high from acceptance until the response is loaded
// a pending response waits in its register; the next request is accepted meanwhile
module first_fit_heap_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        opcode,
	input  logic [15:0] request_size,
	input  logic [11:0] release_offset,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [11:0] granted_offset
);

	`include "first_fit_heap_allocator_core_defines.svh"

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_A_RD, S_A_CHK, S_A_WN, S_A_RS, S_A_WS, S_A_WH,
		S_F_RH, S_F_CH, S_F_RP, S_F_GP, S_F_RS, S_F_GS, S_F_RA, S_F_WA,
		S_F_S1, S_F_S2, S_F_WS, S_F_WH, S_F_WT,
		S_DONE
	} state_t;

	localparam ffha_pkg::addr_t HALF_A = ffha_pkg::AW'(ffha_pkg::HALF_HEAP);
	localparam ffha_pkg::addr_t HDR_A  = ffha_pkg::AW'(ffha_pkg::HEADER_BYTES);
	localparam ffha_pkg::addr_t INIT_SIZE = ffha_pkg::AW'(ffha_pkg::MAX_REQ);

	state_t          state_q;
	ffha_pkg::addr_t clr_q, p_q, at_q, post_q, sz_q, acc_q;
	ffha_pkg::hdr_t  h_q, pp_q, s_q;
	logic            pfree_q, split_q;
	logic [2:0]      res_status_q, status_q;
	logic [11:0]     res_granted_q, granted_q;
	logic            rsp_valid_q;

	logic            mem_we;
	ffha_pkg::addr_t mem_addr;
	ffha_pkg::hdr_t  mem_wdata, rdata, init_hdr;

	logic            pf, sf, fit, take_out;
	ffha_pkg::addr_t tgt;

	ffha_hdr_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rdata)
	);

	assign pf  = h_q.has_prev && pfree_q;
	assign sf  = h_q.has_succ && s_q.is_free;
	assign tgt = pf ? h_q.prev : at_q;
	assign fit = rdata.is_free && (rdata.size >= sz_q);
	assign take_out = !rsp_valid_q || !rsp_stall;

	always_comb begin
		init_hdr = '0;
		if (clr_q == '0 || clr_q == HALF_A) begin
			init_hdr.size    = INIT_SIZE;
			init_hdr.is_free = 1'b1;
			init_hdr.mark    = 1'b1;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = p_q;
		mem_wdata = h_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = init_hdr;
			end
			S_A_RD: mem_addr = p_q;
			S_A_WN: begin
				mem_we             = 1'b1;
				mem_addr           = post_q;
				mem_wdata.prev     = p_q;
				mem_wdata.has_prev = 1'b1;
				mem_wdata.succ     = h_q.succ;
				mem_wdata.has_succ = h_q.has_succ;
				mem_wdata.size     = h_q.size - HDR_A - sz_q;
				mem_wdata.is_free  = 1'b1;
				mem_wdata.mark     = 1'b1;
			end
			S_A_RS: mem_addr = h_q.succ;
			S_A_WS: begin
				mem_we             = 1'b1;
				mem_addr           = h_q.succ;
				mem_wdata          = rdata;
				mem_wdata.prev     = post_q;
				mem_wdata.has_prev = 1'b1;
			end
			S_A_WH: begin
				mem_we            = 1'b1;
				mem_addr          = p_q;
				mem_wdata         = h_q;
				mem_wdata.is_free = 1'b0;
				mem_wdata.mark    = 1'b1;
				if (split_q) begin
					mem_wdata.succ     = post_q;
					mem_wdata.has_succ = 1'b1;
					mem_wdata.size     = sz_q;
				end
			end
			S_F_RH: mem_addr = at_q;
			S_F_RP: mem_addr = h_q.prev;
			S_F_RS: mem_addr = h_q.succ;
			S_F_RA: mem_addr = s_q.succ;
			S_F_WA: begin
				mem_we             = 1'b1;
				mem_addr           = s_q.succ;
				mem_wdata          = rdata;
				mem_wdata.prev     = tgt;
				mem_wdata.has_prev = 1'b1;
			end
			S_F_WS: begin
				mem_we    = h_q.has_succ && (pf || sf);
				mem_addr  = h_q.succ;
				mem_wdata = s_q;
				if (pf) begin
					mem_wdata.prev     = tgt;
					mem_wdata.has_prev = 1'b1;
				end
				if (sf) begin
					mem_wdata.mark = 1'b0;
				end
			end
			S_F_WH: begin
				mem_we         = pf;
				mem_addr       = at_q;
				mem_wdata      = h_q;
				mem_wdata.mark = 1'b0;
			end
			S_F_WT: begin
				mem_we            = 1'b1;
				mem_addr          = tgt;
				mem_wdata         = pf ? pp_q : h_q;
				mem_wdata.is_free = 1'b1;
				mem_wdata.size    = acc_q;
				mem_wdata.succ    = sf ? s_q.succ : h_q.succ;
				mem_wdata.has_succ = sf ? s_q.has_succ : h_q.has_succ;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ffha_pkg::AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						res_granted_q <= '0;
						res_status_q  <= ffha_pkg::ST_OK;
						if (opcode == ffha_pkg::OP_ALLOC) begin
							sz_q <= request_size[ffha_pkg::AW-1:0];
							p_q  <= (ffha_pkg::HAS_BIG &&
								request_size > 16'(ffha_pkg::SMALL_MAX)) ? HALF_A : '0;
							if (request_size > 16'(ffha_pkg::MAX_REQ)) begin
								res_status_q <= ffha_pkg::ST_TOO_LARGE;
								state_q      <= S_DONE;
							end else if (request_size == '0) begin
								res_status_q <= ffha_pkg::ST_ZERO;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_A_RD;
							end
						end else begin
							at_q    <= release_offset - HDR_A;
							pfree_q <= 1'b0;
							if (release_offset == '0) begin
								res_status_q <= ffha_pkg::ST_NULL_FREE;
								state_q      <= S_DONE;
							end else if (release_offset < HDR_A) begin
								res_status_q <= ffha_pkg::ST_BAD_FREE;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_F_RH;
							end
						end
					end
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					h_q     <= rdata;
					post_q  <= p_q + HDR_A + sz_q;
					split_q <= rdata.size > (sz_q + HDR_A);
					if (fit) begin
						state_q <= (rdata.size > (sz_q + HDR_A)) ? S_A_WN : S_A_WH;
					end else if (!rdata.has_succ || rdata.succ == HALF_A) begin
						res_status_q <= ffha_pkg::ST_NO_ROOM;
						state_q      <= S_DONE;
					end else begin
						p_q     <= rdata.succ;
						state_q <= S_A_RD;
					end
				end
				S_A_WN: state_q <= h_q.has_succ ? S_A_RS : S_A_WH;
				S_A_RS: state_q <= S_A_WS;
				S_A_WS: state_q <= S_A_WH;
				S_A_WH: begin
					res_granted_q <= p_q + HDR_A;
					state_q       <= S_DONE;
				end
				S_F_RH: state_q <= S_F_CH;
				S_F_CH: begin
					h_q <= rdata;
					if (!rdata.mark) begin
						res_status_q <= ffha_pkg::ST_BAD_FREE;
						state_q      <= S_DONE;
					end else if (rdata.is_free) begin
						res_status_q <= ffha_pkg::ST_DBL_FREE;
						state_q      <= S_DONE;
					end else if (rdata.has_prev) begin
						state_q <= S_F_RP;
					end else if (rdata.has_succ) begin
						state_q <= S_F_RS;
					end else begin
						state_q <= S_F_S1;
					end
				end
				S_F_RP: state_q <= S_F_GP;
				S_F_GP: begin
					pp_q    <= rdata;
					pfree_q <= rdata.is_free;
					state_q <= h_q.has_succ ? S_F_RS : S_F_S1;
				end
				S_F_RS: state_q <= S_F_GS;
				S_F_GS: begin
					s_q     <= rdata;
					state_q <= (rdata.is_free && rdata.has_succ) ? S_F_RA : S_F_S1;
				end
				S_F_RA: state_q <= S_F_WA;
				S_F_WA: state_q <= S_F_S1;
				S_F_S1: begin
					acc_q   <= pf ? (pp_q.size + HDR_A + h_q.size) : h_q.size;
					state_q <= S_F_S2;
				end
				S_F_S2: begin
					if (sf) begin
						acc_q <= acc_q + HDR_A + s_q.size;
					end
					state_q <= S_F_WS;
				end
				S_F_WS: state_q <= S_F_WH;
				S_F_WH: state_q <= S_F_WT;
				S_F_WT: state_q <= S_DONE;
				S_DONE: begin
					if (take_out) begin
						rsp_valid_q <= 1'b1;
						status_q    <= res_status_q;
						granted_q   <= res_granted_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall      = state_q != S_IDLE;
	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign granted_offset = granted_q;

	`FFHA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	`FFHA_ASSERT_NOW(a_no_write_idle, state_q == S_IDLE, !mem_we)
	`FFHA_ASSERT_NOW(a_grant_only_ok, rsp_valid && granted_offset != '0, status == ffha_pkg::ST_OK)
	`FFHA_ASSERT_NOW(a_grant_past_hdr, rsp_valid && granted_offset != '0, granted_offset >= HDR_A)

endmodule

/* tb/tb_first_fit_heap_allocator_core.sv */
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_core;

	typedef struct {
		int unsigned prev;
		int unsigned succ;
		int unsigned size;
		bit has_prev;
		bit has_succ;
		bit is_free;
		bit mark;
	} blk_t;

	class heap_scoreboard;
		blk_t blocks[ffha_pkg::HEAP_BYTES];
		logic [2:0] exp_status[$];
		logic [11:0] exp_offset[$];
		int errors;

		function void clear();
			blk_t z;
			z = '{default: 0};
			foreach (blocks[i]) blocks[i] = z;
			blocks[0] = '{0, 0, ffha_pkg::HALF_HEAP - ffha_pkg::HEADER_BYTES, 0, 0, 1, 1};
			blocks[ffha_pkg::HALF_HEAP] =
				'{0, 0, ffha_pkg::HALF_HEAP - ffha_pkg::HEADER_BYTES, 0, 0, 1, 1};
			exp_status.delete();
			exp_offset.delete();
			errors = 0;
		endfunction

		function logic [2:0] allocate(int unsigned sz, output int unsigned grant);
			int unsigned p, post;
			grant = 0;
			if (sz + ffha_pkg::HEADER_BYTES > ffha_pkg::HALF_HEAP) return ffha_pkg::ST_TOO_LARGE;
			if (sz == 0) return ffha_pkg::ST_ZERO;
			p = (ffha_pkg::HAS_BIG && sz > ffha_pkg::SMALL_MAX) ? ffha_pkg::HALF_HEAP : 0;
			for (int g = 0; g < ffha_pkg::HEAP_BYTES; g++) begin
				p = p % ffha_pkg::HEAP_BYTES;
				if (blocks[p].size >= sz && blocks[p].is_free) begin
					if (blocks[p].size > sz + ffha_pkg::HEADER_BYTES) begin
						post = (p + ffha_pkg::HEADER_BYTES + sz) % ffha_pkg::HEAP_BYTES;
						blocks[post].prev = p;
						blocks[post].has_prev = 1;
						blocks[post].succ = blocks[p].succ;
						blocks[post].has_succ = blocks[p].has_succ;
						if (blocks[p].has_succ) begin
							blocks[blocks[p].succ % ffha_pkg::HEAP_BYTES].prev = post;
							blocks[blocks[p].succ % ffha_pkg::HEAP_BYTES].has_prev = 1;
						end
						blocks[p].succ = post;
						blocks[p].has_succ = 1;
						blocks[post].size = blocks[p].size - ffha_pkg::HEADER_BYTES - sz;
						blocks[post].is_free = 1;
						blocks[post].mark = 1;
						blocks[p].size = sz;
					end
					blocks[p].is_free = 0;
					blocks[p].mark = 1;
					grant = p + ffha_pkg::HEADER_BYTES;
					return ffha_pkg::ST_OK;
				end
				if (!blocks[p].has_succ) break;
				p = blocks[p].succ % ffha_pkg::HEAP_BYTES;
				if (p == ffha_pkg::HALF_HEAP) break;
			end
			return ffha_pkg::ST_NO_ROOM;
		endfunction

		function logic [2:0] release_block(int unsigned q);
			int unsigned at, pred, nx, nn;
			if (q == 0) return ffha_pkg::ST_NULL_FREE;
			if (q < ffha_pkg::HEADER_BYTES || q - ffha_pkg::HEADER_BYTES >= ffha_pkg::HEAP_BYTES)
				return ffha_pkg::ST_BAD_FREE;
			at = q - ffha_pkg::HEADER_BYTES;
			if (!blocks[at].mark) return ffha_pkg::ST_BAD_FREE;
			if (blocks[at].is_free) return ffha_pkg::ST_DBL_FREE;
			if (blocks[at].has_prev && blocks[blocks[at].prev % ffha_pkg::HEAP_BYTES].is_free) begin
				pred = blocks[at].prev % ffha_pkg::HEAP_BYTES;
				blocks[pred].size += ffha_pkg::HEADER_BYTES + blocks[at].size;
				blocks[pred].succ = blocks[at].succ;
				blocks[pred].has_succ = blocks[at].has_succ;
				if (blocks[at].has_succ) begin
					blocks[blocks[at].succ % ffha_pkg::HEAP_BYTES].prev = pred;
					blocks[blocks[at].succ % ffha_pkg::HEAP_BYTES].has_prev = 1;
				end
				blocks[at].mark = 0;
			end else begin
				blocks[at].is_free = 1;
				pred = at;
			end
			nx = blocks[at].succ % ffha_pkg::HEAP_BYTES;
			if (blocks[at].has_succ && blocks[nx].is_free) begin
				blocks[pred].size += ffha_pkg::HEADER_BYTES + blocks[nx].size;
				blocks[pred].succ = blocks[nx].succ;
				blocks[pred].has_succ = blocks[nx].has_succ;
				if (blocks[nx].has_succ) begin
					nn = blocks[nx].succ % ffha_pkg::HEAP_BYTES;
					blocks[nn].prev = pred;
					blocks[nn].has_prev = 1;
				end
				blocks[nx].mark = 0;
			end
			return ffha_pkg::ST_OK;
		endfunction

		function void note_request(logic op, logic [15:0] sz, logic [11:0] off);
			int unsigned g;
			logic [2:0] st;
			g = 0;
			if (op == ffha_pkg::OP_ALLOC) st = allocate(32'(sz), g);
			else st = release_block(32'(off));
			exp_status.push_back(st);
			exp_offset.push_back(g[11:0]);
		endfunction

		function void check_response(logic [2:0] st, logic [11:0] off);
			if (exp_status.size() == 0) begin
				$display("%0t unexpected response status %0d offset %0d", $time, st, off);
				errors++;
				return;
			end
			if (st !== exp_status[0]) begin
				$display("%0t status expected %0d actual %0d", $time, exp_status[0], st);
				errors++;
			end
			if (off !== exp_offset[0]) begin
				$display("%0t offset expected %0d actual %0d", $time, exp_offset[0], off);
				errors++;
			end
			void'(exp_status.pop_front());
			void'(exp_offset.pop_front());
		endfunction
	endclass

	logic clk, arst_n;
	logic req_valid, req_stall, opcode;
	logic [15:0] request_size;
	logic [11:0] release_offset;
	logic rsp_valid, rsp_stall;
	logic [2:0] status;
	logic [11:0] granted_offset;

	heap_scoreboard sb;
	int unsigned cycles;
	int stall_left;
	logic [11:0] live[$];

	first_fit_heap_allocator_core DUT (.*);

	initial clk = 0;
	always #10 clk = ~clk;

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	task automatic send(logic op, logic [15:0] sz, logic [11:0] off);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		repeat (gap + 1) @(posedge clk);
		req_valid <= 1;
		opcode <= op;
		request_size <= sz;
		release_offset <= off;
		do @(posedge clk); while (req_stall);
		sb.note_request(op, sz, off);
		if (op == ffha_pkg::OP_ALLOC && sb.exp_status[$] == ffha_pkg::ST_OK)
			live.push_back(sb.exp_offset[$]);
		req_valid <= 0;
	endtask

	task automatic alloc_req(logic [15:0] sz);
		send(ffha_pkg::OP_ALLOC, sz, 12'($urandom));
	endtask

	task automatic free_req(logic [11:0] off);
		send(ffha_pkg::OP_FREE, 16'($urandom), off);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) sb.check_response(status, granted_offset);
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1;
			end else if ($urandom_range(0, 2) == 0) begin
				stall_left = pick_gap();
				rsp_stall <= (stall_left > 0);
			end else begin
				rsp_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int idx, w;
		logic [11:0] x;
		sb = new();
		sb.clear();
		cycles = 0;
		stall_left = 0;
		arst_n = 0;
		req_valid = 0;
		opcode = 0;
		request_size = 0;
		release_offset = 0;
		rsp_stall = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		// directed
		alloc_req(16'hFFFF);
		alloc_req(16'(ffha_pkg::MAX_REQ + 1));
		alloc_req(16'd0);
		free_req(12'd0);
		free_req(12'd5);
		free_req(12'hFFF);
		alloc_req(16'd1);
		alloc_req(16'(ffha_pkg::SMALL_MAX));
		alloc_req(16'(ffha_pkg::SMALL_MAX + 1));
		alloc_req(16'(ffha_pkg::MAX_REQ));
		alloc_req(16'd100);
		free_req(12'd32);
		free_req(12'd32);
		free_req(live[1]);
		free_req(live[2]);
		free_req(12'd65);
		alloc_req(16'(ffha_pkg::MAX_REQ));
		free_req(live[3]);
		alloc_req(16'(ffha_pkg::MAX_REQ));
		alloc_req(16'h5555);
		alloc_req(16'hAAAA);
		free_req(12'hAAA);
		free_req(12'h555);
		// random
		for (int n = 0; n < 750; n++) begin
			w = $urandom_range(0, 99);
			if (w < 45) begin
				if ($urandom_range(0, 3) == 0)
					alloc_req(16'($urandom_range(ffha_pkg::SMALL_MAX + 1, ffha_pkg::MAX_REQ)));
				else if ($urandom_range(0, 1))
					alloc_req(16'($urandom_range(1, ffha_pkg::SMALL_MAX)));
				else alloc_req(16'($urandom_range(1, 200)));
			end else if (w < 80 && live.size() > 0) begin
				idx = $urandom_range(0, live.size() - 1);
				x = live[idx];
				if ($urandom_range(0, 4) != 0) live.delete(idx);
				free_req(x);
			end else if (w < 90) begin
				alloc_req(16'($urandom));
			end else begin
				free_req(12'($urandom));
			end
		end
		w = 0;
		while (sb.exp_status.size() != 0 && w < 200000) begin
			@(posedge clk);
			w++;
		end
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.exp_status.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
